// ===== sv/dbsr_pkg.sv =====
// Shared constants for the dense to block sparse row encoder.
`default_nettype none
package dbsr_pkg;

   // default geometry
   localparam int BLOCK_DEFAULT    = 32;
   localparam int MAX_COLS_DEFAULT = 256;

   // field widths
   localparam int ELEM_W    = 32;
   localparam int PAYLOAD_W = 32;
   localparam int KIND_W    = 2;
   localparam int ROWS_W    = 16;
   localparam int COLS_W    = 9;
   localparam int BLOCKS_W  = 20;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   // input command codes
   localparam logic CMD_ELEMENT = 1'b0;
   localparam logic CMD_DRAIN   = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_VALUE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BLK_COL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ROW_PTR = 2'd2;
   localparam logic [KIND_W-1:0] KIND_IDLE    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 1'b1;

endpackage
`default_nettype wire

// ===== sv/dbsr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module dbsr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/dense_to_block_sparse_row_encoder_top.sv =====
// Top level of the dense to block sparse row (BSR) encoder.
`default_nettype none
// Dense matrix elements (raw single-precision bits, row-major) enter on the
// req_ channel with tuser = 0; they carry no result. Once BLOCK matrix rows,
// or the last row of the matrix, have been received, the block row sits in
// a BLOCK x MAX_COLS word RAM and the encoder is draining: each beat with
// tuser = 1 returns exactly one rsp_ beat. For every block holding a value
// whose magnitude is nonzero (-0.0 counts as zero, NaN as nonzero), left to
// right, the encoder returns the block column index (kind 1) and then its
// BLOCK*BLOCK value words in row-major order (kind 0), with positions
// outside the matrix reading as zero. A row pointer entry (kind 2, the
// running block count) closes each block row; rsp_tlast marks the one that
// closes the matrix, after which the counters restart for the next matrix.
// A drain beat while nothing is buffered answers kind 3 with payload 0, and
// element beats sent during a drain are dropped. Throughput is one beat per
// cycle on either kind while the result channel does not stall; a drain
// result passes the synchronous RAM read and then the output register, and
// a stalled result stalls at most one further request.
// The RAM needs no clearing pass after reset: only positions written in the
// current block row are ever read. Write rows_in_use (index 0) and
// cols_in_use (index 1) on the csr_ port between matrices.
module dense_to_block_sparse_row_encoder_top #(
   parameter int BLOCK    = dbsr_pkg::BLOCK_DEFAULT,
   parameter int MAX_COLS = dbsr_pkg::MAX_COLS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input channel
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [dbsr_pkg::ELEM_W-1:0]     req_tdata,   // [31:0] element
   input  wire logic                            req_tuser,   // [0] cmd
   // result channel
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [dbsr_pkg::PAYLOAD_W-1:0]       rsp_tdata,   // [31:0] payload
   output logic [dbsr_pkg::KIND_W-1:0]          rsp_tuser,   // [1:0] kind
   output logic                                 rsp_tlast,   // matrix_done
   // configuration port
   input  wire logic                            csr_wr_en,
   input  wire logic [dbsr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dbsr_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   import dbsr_pkg::*;

   // geometry
   localparam int MARKS  = (MAX_COLS + BLOCK - 1) / BLOCK;
   localparam int DBCW   = $clog2(MARKS + 1);
   localparam int BW     = (BLOCK > 1) ? $clog2(BLOCK) : 1;
   localparam int DEPTH  = BLOCK * MAX_COLS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CPW    = $clog2(MARKS * BLOCK + BLOCK + 1);
   localparam int MCW    = $clog2(MAX_COLS + 1);
   localparam int ECW0   = (CPW > COLS_W) ? CPW : COLS_W;
   localparam int ECW    = (MCW > ECW0) ? MCW : ECW0;

   // configuration
   logic [ROWS_W-1:0] rows_ff, rows_in;
   logic [COLS_W-1:0] cols_ff, cols_in;

   // dense position and drain state
   logic [ROWS_W-1:0]   row_ff, row_in;
   logic [BW-1:0]       rib_ff, rib_in;        // row within the block row
   logic [COLS_W-1:0]   col_ff, col_in;
   logic [BLOCKS_W-1:0] blocks_ff, blocks_in;
   logic [MARKS-1:0]    marks_ff, marks_in;
   logic                draining_ff, draining_in;
   logic [DBCW-1:0]     dbc_ff, dbc_in;        // drain block column
   logic                hdr_ff, hdr_in;        // block column index already sent
   logic [BW-1:0]       dr_ff, dr_in;          // drain row within block
   logic [BW-1:0]       dc_ff, dc_in;          // drain column within block

   // read stage and output register
   logic                 s1_valid_ff, s1_valid_in;
   logic [KIND_W-1:0]    s1_kind_ff, s1_kind_in;
   logic [PAYLOAD_W-1:0] s1_payload_ff, s1_payload_in;
   logic                 s1_done_ff, s1_done_in;
   logic                 s1_mem_ff, s1_mem_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic                 rsp_done_ff, rsp_done_in;

   // RAM ports
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [ELEM_W-1:0]    rd_data;

   // working signals
   logic                 out_free;
   logic                 accept;
   logic [ROWS_W-1:0]    eff_rows;
   logic [ECW-1:0]       eff_cols;
   logic [ECW-1:0]       col_ext;
   logic                 col_in_range;
   logic                 elem_nonzero;
   logic [COLS_W-1:0]    col_next;
   logic [BW-1:0]        rib_next;
   logic [ROWS_W-1:0]    row_next;
   logic [MARKS-1:0]     cand;
   logic                 found_any;
   logic [DBCW-1:0]      found_idx;
   logic [ECW-1:0]       c_pos;
   logic                 row_ok;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   // effective limits
   always_comb begin
      eff_rows = (rows_ff == '0) ? ROWS_W'(1) : rows_ff;
      if (cols_ff == '0) begin
         eff_cols = ECW'(1);
      end else if (ECW'(cols_ff) > ECW'(MAX_COLS)) begin
         eff_cols = ECW'(MAX_COLS);
      end else begin
         eff_cols = ECW'(cols_ff);
      end
   end

   // configuration writes
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ROWS_IN_USE: rows_in = csr_wr_data[ROWS_W-1:0];
            CSR_COLS_IN_USE: cols_in = csr_wr_data[COLS_W-1:0];
            default: ;
         endcase
      end
   end

   // element path: position, store address and block marks
   assign col_ext      = ECW'(col_ff);
   assign col_in_range = col_ext < ECW'(MAX_COLS);
   assign elem_nonzero = req_tdata[ELEM_W-2:0] != '0;
   assign col_next     = col_ff + COLS_W'(1);
   assign rib_next     = (rib_ff == BW'(BLOCK - 1)) ? '0 : rib_ff + BW'(1);
   assign row_next     = row_ff + ROWS_W'(1);
   assign wr_addr      = AW'(AW'(rib_ff) * AW'(MAX_COLS) + AW'(col_ff));

   // drain path: next marked block column still inside the matrix
   always_comb begin
      for (int j = 0; j < MARKS; j++) begin
         cand[j] = marks_ff[j] && (ECW'(j * BLOCK) < eff_cols) && (DBCW'(j) >= dbc_ff);
      end
      found_any = |cand;
      found_idx = '0;
      for (int j = MARKS - 1; j >= 0; j--) begin
         if (cand[j]) begin
            found_idx = DBCW'(j);
         end
      end
   end

   assign c_pos   = ECW'(found_idx) * ECW'(BLOCK) + ECW'(dc_ff);
   assign rd_addr = AW'(AW'(dr_ff) * AW'(MAX_COLS) + AW'(c_pos));
   // rows received in this block row: all BLOCK when the row count sits on a
   // block boundary, else the remainder
   assign row_ok  = (row_ff != '0) && ((rib_ff == '0) || (dr_ff < rib_ff));

   always_comb begin
      row_in      = row_ff;
      rib_in      = rib_ff;
      col_in      = col_ff;
      blocks_in   = blocks_ff;
      marks_in    = marks_ff;
      draining_in = draining_ff;
      dbc_in      = dbc_ff;
      hdr_in      = hdr_ff;
      dr_in       = dr_ff;
      dc_in       = dc_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      s1_kind_in    = KIND_IDLE;
      s1_payload_in = '0;
      s1_done_in    = 1'b0;
      s1_mem_in     = 1'b0;

      if (accept && req_tuser == CMD_ELEMENT && !draining_ff) begin
         // take one dense element
         wr_en = col_in_range;
         for (int j = 0; j < MARKS; j++) begin
            if (col_in_range && elem_nonzero && col_ext >= ECW'(j * BLOCK)
                && col_ext < ECW'((j + 1) * BLOCK)) begin
               marks_in[j] = 1'b1;
            end
         end
         col_in = col_next;
         if (ECW'(col_next) >= eff_cols || col_next == '0) begin
            col_in = '0;
            row_in = row_next;
            rib_in = rib_next;
            if (rib_next == '0 || row_next >= eff_rows) begin
               draining_in = 1'b1;
               dbc_in      = '0;
               hdr_in      = 1'b0;
               dr_in       = '0;
               dc_in       = '0;
            end
         end
      end else if (accept && req_tuser == CMD_DRAIN && draining_ff) begin
         if (!found_any) begin
            // close the block row with its row pointer entry
            s1_kind_in    = KIND_ROW_PTR;
            s1_payload_in = PAYLOAD_W'(blocks_ff);
            s1_done_in    = row_ff >= eff_rows;
            marks_in      = '0;
            draining_in   = 1'b0;
            dbc_in        = '0;
            hdr_in        = 1'b0;
            dr_in         = '0;
            dc_in         = '0;
            if (row_ff >= eff_rows) begin
               row_in    = '0;
               rib_in    = '0;
               col_in    = '0;
               blocks_in = '0;
            end
         end else if (!hdr_ff) begin
            s1_kind_in    = KIND_BLK_COL;
            s1_payload_in = PAYLOAD_W'(found_idx);
            blocks_in     = blocks_ff + BLOCKS_W'(1);
            dbc_in        = found_idx;
            hdr_in        = 1'b1;
            dr_in         = '0;
            dc_in         = '0;
         end else begin
            // value word: fetch from the RAM, or zero outside the matrix
            s1_kind_in = KIND_VALUE;
            s1_mem_in  = row_ok && (c_pos < eff_cols) && (c_pos < ECW'(MAX_COLS));
            rd_en      = s1_mem_in;
            dbc_in     = found_idx;
            if (dc_ff == BW'(BLOCK - 1)) begin
               dc_in = '0;
               if (dr_ff == BW'(BLOCK - 1)) begin
                  dr_in  = '0;
                  hdr_in = 1'b0;
                  dbc_in = found_idx + DBCW'(1);
               end else begin
                  dr_in = dr_ff + BW'(1);
               end
            end else begin
               dc_in = dc_ff + BW'(1);
            end
         end
      end
   end

   // result pipeline: read stage, then output register
   always_comb begin
      s1_valid_in    = (s1_valid_ff && !out_free) || (accept && req_tuser == CMD_DRAIN);
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_done_in    = rsp_done_ff;
      if (out_free) begin
         rsp_valid_in   = s1_valid_ff;
         rsp_kind_in    = s1_kind_ff;
         rsp_payload_in = s1_mem_ff ? PAYLOAD_W'(rd_data) : s1_payload_ff;
         rsp_done_in    = s1_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= ROWS_W'(1);
         cols_ff      <= COLS_W'(1);
         row_ff       <= '0;
         rib_ff       <= '0;
         col_ff       <= '0;
         blocks_ff    <= '0;
         marks_ff     <= '0;
         draining_ff  <= 1'b0;
         dbc_ff       <= '0;
         hdr_ff       <= 1'b0;
         dr_ff        <= '0;
         dc_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         row_ff       <= row_in;
         rib_ff       <= rib_in;
         col_ff       <= col_in;
         blocks_ff    <= blocks_in;
         marks_ff     <= marks_in;
         draining_ff  <= draining_in;
         dbc_ff       <= dbc_in;
         hdr_ff       <= hdr_in;
         dr_ff        <= dr_in;
         dc_ff        <= dc_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: hold while the read stage is stalled
   always_ff @(posedge clock) begin
      if (req_tready) begin
         s1_kind_ff    <= s1_kind_in;
         s1_payload_ff <= s1_payload_in;
         s1_done_ff    <= s1_done_in;
         s1_mem_ff     <= s1_mem_in;
      end
      rsp_kind_ff    <= rsp_kind_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_done_ff    <= rsp_done_in;
   end

   dbsr_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_payload_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_done_ff;

endmodule
`default_nettype wire
